>>> hw/rtl/fcu_pkg.sv
`timescale 1ns / 1ps
package fcu_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	// receive phases
	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_FLAG = 2'd1;
	localparam logic [1:0] PH_IN   = 2'd2;

	localparam int JOB_DEPTH = 2;

	// results caused by one input item, slot 0 goes out first
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [3:0][1:0] kind;
		logic [2:0]      cnt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> hw/rtl/fcu_front.sv
`timescale 1ns / 1ps
module fcu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               direction,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               frame_first,
	input  logic               frame_last,
	output logic               push,
	output fcu_pkg::job_t      job
);

	logic [1:0] rx_phase_q;
	logic       esc_q;
	logic [1:0] phase_nxt;
	logic       esc_nxt;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		logic [2:0] n;
		n         = 3'd0;
		job       = '0;
		phase_nxt = rx_phase_q;
		esc_nxt   = esc_q;
		if (!direction) begin
			if (frame_first) begin
				job.data[n[1:0]] = fcu_pkg::FLAG_BYTE;
				job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
				n = n + 3'd1;
			end
			if (in_byte == fcu_pkg::FLAG_BYTE || in_byte == fcu_pkg::ESC_BYTE) begin
				job.data[n[1:0]] = fcu_pkg::ESC_BYTE;
				job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
				n = n + 3'd1;
				job.data[n[1:0]] = (in_byte == fcu_pkg::FLAG_BYTE) ?
					fcu_pkg::ESC_FLAG : fcu_pkg::ESC_ESC;
				job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
				n = n + 3'd1;
			end else begin
				job.data[n[1:0]] = in_byte;
				job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
				n = n + 3'd1;
			end
			if (frame_last) begin
				job.data[n[1:0]] = fcu_pkg::FLAG_BYTE;
				job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
				n = n + 3'd1;
			end
		end else if (rx_phase_q == fcu_pkg::PH_FLAG || rx_phase_q == fcu_pkg::PH_IN) begin
			if (in_byte == fcu_pkg::FLAG_BYTE) begin
				// repeated opening flags are skipped
				if (rx_phase_q == fcu_pkg::PH_IN) begin
					if (esc_q) begin
						job.data[n[1:0]] = fcu_pkg::ESC_BYTE;
						job.kind[n[1:0]] = fcu_pkg::KIND_BAD;
						n = n + 3'd1;
					end
					job.data[n[1:0]] = 8'h00;
					job.kind[n[1:0]] = fcu_pkg::KIND_END;
					n = n + 3'd1;
					phase_nxt = fcu_pkg::PH_WAIT;
					esc_nxt   = 1'b0;
				end
			end else begin
				phase_nxt = fcu_pkg::PH_IN;
				if (esc_q) begin
					esc_nxt = 1'b0;
					if (in_byte == fcu_pkg::ESC_FLAG) begin
						job.data[n[1:0]] = fcu_pkg::FLAG_BYTE;
						job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
					end else if (in_byte == fcu_pkg::ESC_ESC) begin
						job.data[n[1:0]] = fcu_pkg::ESC_BYTE;
						job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
					end else begin
						job.data[n[1:0]] = in_byte;
						job.kind[n[1:0]] = fcu_pkg::KIND_BAD;
					end
					n = n + 3'd1;
				end else if (in_byte == fcu_pkg::ESC_BYTE) begin
					esc_nxt = 1'b1;
				end else begin
					job.data[n[1:0]] = in_byte;
					job.kind[n[1:0]] = fcu_pkg::KIND_DATA;
					n = n + 3'd1;
				end
			end
		end else if (in_byte == fcu_pkg::FLAG_BYTE) begin
			phase_nxt = fcu_pkg::PH_FLAG;
			esc_nxt   = 1'b0;
		end
		job.cnt = n;
	end

	// items with no result are consumed here and never queued
	assign push = accept && (job.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q <= fcu_pkg::PH_WAIT;
			esc_q      <= 1'b0;
		end else if (accept && direction) begin
			rx_phase_q <= phase_nxt;
			esc_q      <= esc_nxt;
		end
	end

endmodule

>>> hw/rtl/fcu_job_fifo.sv
`timescale 1ns / 1ps
module fcu_job_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fcu_pkg::job_t        wr_job,
	input  logic                 pop,
	output fcu_pkg::job_t        rd_job,
	output fcu_pkg::fifo_stat_t  stat
);

	fcu_pkg::job_t mem_q [fcu_pkg::JOB_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign rd_job     = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'(fcu_pkg::JOB_DEPTH));
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/fcu_back.sv
`timescale 1ns / 1ps
module fcu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fcu_pkg::job_t  head,
	input  logic           head_valid,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic [1:0]     out_kind,
	output logic           out_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_kind_q;
	logic       out_last_q;
	logic       load;
	logic       is_last;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign is_last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.data[idx_q];
			out_kind_q <= head.kind[idx_q];
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

endmodule

>>> hw/rtl/byte_stuffing_frame_codec_unit.sv
`timescale 1ns / 1ps
// Byte-stuffing frame codec (flag 0x7E, escape 0x7D). With direction 0 each
// input byte is framed and escaped into one to four line bytes; with direction
// 1 line bytes are deframed and unescaped into zero to two results (data byte,
// frame end, or bad escape). An input item is accepted in the cycle it arrives
// as long as the two-entry job queue has room; results leave at one per cycle
// from a registered output while the receiver is ready, so an item takes as
// many output transfers as it makes results: 1 to 4 when encoding, 0 to 2
// when decoding. With a ready receiver the output's one byte per cycle sets
// the sustained rate. The direction register sits at APB byte address 0.
module byte_stuffing_frame_codec_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tuser,   // [0] frame_first
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);

	logic                direction_q;
	logic                push;
	logic                pop;
	fcu_pkg::job_t       wr_job;
	fcu_pkg::job_t       head;
	fcu_pkg::fifo_stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, direction_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			direction_q <= pwdata[0];
		end
	end

	assign s_axis_tready = !stat.full;

	fcu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.direction   (direction_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.frame_first (s_axis_tuser),
		.frame_last  (s_axis_tlast),
		.push        (push),
		.job         (wr_job)
	);

	fcu_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (head),
		.stat   (stat)
	);

	fcu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!stat.empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_kind   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("job queue reports full and empty together");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full && wr_job.cnt != 3'd0 && wr_job.cnt <= 3'd4))
		else $error("job pushed into full queue or with bad count");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == fcu_pkg::KIND_END) |->
		(m_axis_tdata == 8'h00 && m_axis_tlast))
		else $error("frame end transaction without zero byte or last mark");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty job queue");

endmodule
